/* hdl/udp_datagram_receive_check_core_defines.svh */
// Assertion helpers shared by the datagram check RTL.
// Each macro expects clk and rst_n in scope.
`ifndef UDP_DATAGRAM_RECEIVE_CHECK_CORE_DEFINES_SVH
`define UDP_DATAGRAM_RECEIVE_CHECK_CORE_DEFINES_SVH

// Property that must hold at every edge outside reset
`define UDC_ASSERT(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Same-cycle implication
`define UDC_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define UDC_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/udc_pkg.sv */
`timescale 1ns / 1ps
package udc_pkg;

  // Header and protocol constants
  localparam logic [15:0] HDR_SIZE    = 16'd8;
  localparam logic [15:0] PROTO_UDP   = 16'd17;
  localparam logic [15:0] PAYLOAD_MAX = 16'd1472;

  // Byte position counter, saturating
  localparam int unsigned POS_W = 17;
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  // Default queue depths
  localparam int unsigned MID_DEPTH_DEF = 2;
  localparam int unsigned OUT_DEPTH_DEF = 2;

  typedef enum logic [2:0] {
    VERDICT_ACCEPT       = 3'd0,
    VERDICT_TOO_SHORT    = 3'd1,
    VERDICT_BAD_LENGTH   = 3'd2,
    VERDICT_TOO_LARGE    = 3'd3,
    VERDICT_BAD_CHECKSUM = 3'd4
  } verdict_t;

  typedef struct packed {
    logic [7:0]  packet_byte;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic        is_last;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  verdict;
    logic [15:0] src_port;
    logic [15:0] dest_port;
    logic [15:0] payload_length;
    logic        checksum_present;
    logic [15:0] computed_checksum;
  } out_item_t;

  // One finished packet, classified, waiting for the checksum finish
  typedef struct packed {
    verdict_t    pre_verdict;
    logic        need_ck;
    logic [15:0] src_port;
    logic [15:0] dest_port;
    logic [15:0] payload_length;
    logic        checksum_present;
    logic [15:0] checksum_field;
    logic [15:0] length_field;
    logic [31:0] word_sum;
    logic [7:0]  high_byte;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
  } pkt_rec_t;

endpackage

/* hdl/udc_fifo.sv */
`timescale 1ns / 1ps
module udc_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wptr_r, wptr_nxt;
  logic [AW-1:0]    rptr_r, rptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rptr_r];

  // pointer and count update
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

`include "udp_datagram_receive_check_core_defines.svh"

  `UDC_ASSERT(a_fifo_cnt_bound, cnt_r <= CW'(DEPTH), "fifo count above depth")
  `UDC_ASSERT_NXT(a_fifo_cnt_inc, do_push && !do_pop, cnt_r == $past(cnt_r) + 1'b1, "fifo count did not grow on push")

endmodule

/* hdl/udc_front.sv */
`timescale 1ns / 1ps
module udc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  udc_pkg::in_item_t  in_item,
  output logic               in_full,
  input  logic               mid_full,
  output logic               mid_push,
  output udc_pkg::pkt_rec_t  mid_rec
);

  logic [udc_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [31:0] sum_r, sum_nxt;
  logic [7:0]  hold_r, hold_nxt;
  logic [15:0] sport_r, sport_nxt;
  logic [15:0] dport_r, dport_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] ck_r, ck_nxt;
  logic [31:0] sip_r, sip_nxt;
  logic [31:0] dip_r, dip_nxt;

  logic       take;
  logic [7:0] b;
  logic [7:0] sum_byte;
  logic       sum_en;

  // any byte may close a packet, so hold off while the queue is full
  assign in_full  = mid_full;
  assign take     = in_push && !in_full;
  assign mid_push = take && in_item.is_last;
  assign b        = in_item.packet_byte;

  // header parse and running word sum
  always_comb begin
    sport_nxt = sport_r;
    dport_nxt = dport_r;
    len_nxt   = len_r;
    ck_nxt    = ck_r;
    sum_nxt   = sum_r;
    hold_nxt  = hold_r;
    sip_nxt   = (pos_r == '0) ? in_item.src_ip : sip_r;
    dip_nxt   = (pos_r == '0) ? in_item.dst_ip : dip_r;

    unique case (pos_r)
      17'd0:   sport_nxt = {b, 8'h00};
      17'd1:   sport_nxt = {sport_r[15:8], b};
      17'd2:   dport_nxt = {b, 8'h00};
      17'd3:   dport_nxt = {dport_r[15:8], b};
      17'd4:   len_nxt   = {b, 8'h00};
      17'd5:   len_nxt   = {len_r[15:8], b};
      17'd6:   ck_nxt    = {b, 8'h00};
      17'd7:   ck_nxt    = {ck_r[15:8], b};
      default: ;
    endcase

    // checksum field bytes count as zero
    sum_byte = ((pos_r == 17'd6) || (pos_r == 17'd7)) ? 8'h00 : b;
    sum_en   = (pos_r < 17'd6) || (pos_r < {1'b0, len_r});
    if (sum_en) begin
      if (!pos_r[0]) begin
        hold_nxt = sum_byte;
      end else begin
        sum_nxt = sum_r + {16'h0000, hold_r, sum_byte};
      end
    end

    pos_nxt = (pos_r == udc_pkg::POS_MAX) ? pos_r : pos_r + 1'b1;
  end

  // classification of the closing byte
  logic [17:0] size_w;
  logic        too_short, bad_len, too_large;
  logic [15:0] plen;

  always_comb begin
    size_w    = {1'b0, pos_r} + 18'd1;
    too_short = (pos_r < 17'd7);
    bad_len   = (len_nxt < udc_pkg::HDR_SIZE) || ({2'b00, len_nxt} > size_w);
    plen      = len_nxt - udc_pkg::HDR_SIZE;
    too_large = (plen > udc_pkg::PAYLOAD_MAX);

    mid_rec                  = '0;
    mid_rec.checksum_field   = ck_nxt;
    mid_rec.length_field     = len_nxt;
    mid_rec.word_sum         = sum_nxt;
    mid_rec.high_byte        = hold_nxt;
    mid_rec.src_ip           = sip_nxt;
    mid_rec.dst_ip           = dip_nxt;
    if (too_short) begin
      mid_rec.pre_verdict = udc_pkg::VERDICT_TOO_SHORT;
    end else begin
      mid_rec.src_port         = sport_nxt;
      mid_rec.dest_port        = dport_nxt;
      mid_rec.checksum_present = (ck_nxt != 16'h0000);
      if (bad_len) begin
        mid_rec.pre_verdict = udc_pkg::VERDICT_BAD_LENGTH;
      end else begin
        mid_rec.payload_length = plen;
        if (too_large) begin
          mid_rec.pre_verdict = udc_pkg::VERDICT_TOO_LARGE;
        end else begin
          mid_rec.pre_verdict = udc_pkg::VERDICT_ACCEPT;
          mid_rec.need_ck     = 1'b1;
        end
      end
    end
  end

  // packet state: cleared after each closing byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      sum_r   <= '0;
      hold_r  <= '0;
      sport_r <= '0;
      dport_r <= '0;
      len_r   <= '0;
      ck_r    <= '0;
      sip_r   <= '0;
      dip_r   <= '0;
    end else if (take) begin
      if (in_item.is_last) begin
        pos_r   <= '0;
        sum_r   <= '0;
        hold_r  <= '0;
        sport_r <= '0;
        dport_r <= '0;
        len_r   <= '0;
        ck_r    <= '0;
        sip_r   <= '0;
        dip_r   <= '0;
      end else begin
        pos_r   <= pos_nxt;
        sum_r   <= sum_nxt;
        hold_r  <= hold_nxt;
        sport_r <= sport_nxt;
        dport_r <= dport_nxt;
        len_r   <= len_nxt;
        ck_r    <= ck_nxt;
        sip_r   <= sip_nxt;
        dip_r   <= dip_nxt;
      end
    end
  end

`include "udp_datagram_receive_check_core_defines.svh"

  `UDC_ASSERT_NXT(a_front_restart, take && in_item.is_last, pos_r == '0, "position not cleared")

endmodule

/* hdl/udc_back.sv */
`timescale 1ns / 1ps
module udc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               mid_empty,
  output logic               mid_pop,
  input  udc_pkg::pkt_rec_t  mid_rec,
  input  logic               out_full,
  output logic               out_push,
  output udc_pkg::out_item_t out_res
);

  // fields that ride along the finish pipeline
  typedef struct packed {
    udc_pkg::verdict_t pre_verdict;
    logic              need_ck;
    logic [15:0]       src_port;
    logic [15:0]       dest_port;
    logic [15:0]       payload_length;
    logic              checksum_present;
    logic [15:0]       checksum_field;
  } side_t;

  logic        en;
  side_t       side_in;
  logic [18:0] pseudo;

  logic        s1_v_r, s2_v_r, s3_v_r;
  side_t       s1_side_r, s2_side_r, s3_side_r;
  logic [31:0] s1_sum_r;
  logic [18:0] s1_pseudo_r;
  logic [31:0] s2_sum_r;
  logic [16:0] s3_fold_r;

  // whole pipe stalls only when its tail cannot leave
  assign en       = !(s3_v_r && out_full);
  assign mid_pop  = en && !mid_empty;
  assign out_push = s3_v_r && !out_full;

  // stage 1 input: pseudo header words and odd-length pad
  always_comb begin
    side_in.pre_verdict      = mid_rec.pre_verdict;
    side_in.need_ck          = mid_rec.need_ck;
    side_in.src_port         = mid_rec.src_port;
    side_in.dest_port        = mid_rec.dest_port;
    side_in.payload_length   = mid_rec.payload_length;
    side_in.checksum_present = mid_rec.checksum_present;
    side_in.checksum_field   = mid_rec.checksum_field;
    pseudo = {3'b000, mid_rec.src_ip[31:16]} + {3'b000, mid_rec.src_ip[15:0]}
           + {3'b000, mid_rec.dst_ip[31:16]} + {3'b000, mid_rec.dst_ip[15:0]}
           + {3'b000, udc_pkg::PROTO_UDP} + {3'b000, mid_rec.length_field}
           + (mid_rec.length_field[0] ? {3'b000, mid_rec.high_byte, 8'h00} : 19'd0);
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= !mid_empty;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  // data path: add pseudo header, then first fold
  always_ff @(posedge clk) begin
    if (en) begin
      s1_side_r   <= side_in;
      s1_sum_r    <= mid_rec.word_sum;
      s1_pseudo_r <= pseudo;
      s2_side_r   <= s1_side_r;
      s2_sum_r    <= s1_sum_r + {13'd0, s1_pseudo_r};
      s3_side_r   <= s2_side_r;
      s3_fold_r   <= {1'b0, s2_sum_r[15:0]} + {1'b0, s2_sum_r[31:16]};
    end
  end

  // second fold, invert, verdict
  logic [15:0] fold2, inv, comp;
  logic        s3_reject;

  assign s3_reject = s3_v_r && !s3_side_r.need_ck;

  always_comb begin
    fold2 = s3_fold_r[15:0] + {15'h0000, s3_fold_r[16]};
    inv   = ~fold2;
    comp  = (inv == 16'h0000) ? 16'hffff : inv;

    out_res.src_port         = s3_side_r.src_port;
    out_res.dest_port        = s3_side_r.dest_port;
    out_res.payload_length   = s3_side_r.payload_length;
    out_res.checksum_present = s3_side_r.checksum_present;
    if (s3_side_r.need_ck) begin
      out_res.computed_checksum = comp;
      if (s3_side_r.checksum_present && (comp != s3_side_r.checksum_field)) begin
        out_res.verdict = udc_pkg::VERDICT_BAD_CHECKSUM;
      end else begin
        out_res.verdict = udc_pkg::VERDICT_ACCEPT;
      end
    end else begin
      out_res.computed_checksum = 16'h0000;
      out_res.verdict           = s3_side_r.pre_verdict;
    end
  end

`include "udp_datagram_receive_check_core_defines.svh"

  `UDC_ASSERT_NXT(a_back_hold, s3_v_r && out_full, s3_v_r, "stalled result dropped")
  `UDC_ASSERT_IMP(a_back_ckonly, s3_reject, out_res.computed_checksum == 16'h0000, "ck on reject")

endmodule

/* hdl/udp_datagram_receive_check_core.sv */
`timescale 1ns / 1ps
// Throughput: one packet byte accepted per cycle while in_full is low; one result
// per cycle at most. A packet's result passes the mid queue, the finish stages
// (pseudo header add, 32-bit add, first fold) and the result queue to out_ ports.
// The byte loop is the front parser; the checksum finish is a 3-stage pipe.
// Reset (rst_n low, synchronous) clears packet state, pipe valids and both queues.
module udp_datagram_receive_check_core #(
  parameter int unsigned MID_DEPTH = udc_pkg::MID_DEPTH_DEF,
  parameter int unsigned OUT_DEPTH = udc_pkg::OUT_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  udc_pkg::in_item_t  in_item,
  output logic               in_full,
  output logic               out_empty,
  input  logic               out_pop,
  output udc_pkg::out_item_t out_item
);

  logic              mid_push, mid_full, mid_pop, mid_empty;
  udc_pkg::pkt_rec_t mid_wr, mid_rd;
  logic              res_push, res_full;
  udc_pkg::out_item_t res_wr;

  udc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_item  (in_item),
    .in_full  (in_full),
    .mid_full (mid_full),
    .mid_push (mid_push),
    .mid_rec  (mid_wr)
  );

  // packets between parser and checksum finish
  udc_fifo #(
    .WIDTH ($bits(udc_pkg::pkt_rec_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (mid_push),
    .wr_data (mid_wr),
    .full    (mid_full),
    .pop     (mid_pop),
    .rd_data (mid_rd),
    .empty   (mid_empty)
  );

  udc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_empty (mid_empty),
    .mid_pop   (mid_pop),
    .mid_rec   (mid_rd),
    .out_full  (res_full),
    .out_push  (res_push),
    .out_res   (res_wr)
  );

  // result queue toward the consumer
  udc_fifo #(
    .WIDTH ($bits(udc_pkg::out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (res_wr),
    .full    (res_full),
    .pop     (out_pop),
    .rd_data (out_item),
    .empty   (out_empty)
  );

endmodule

/* tb/tb_udp_datagram_receive_check_core.sv */
`timescale 1ns / 1ps
module tb_udp_datagram_receive_check_core;

  typedef logic [7:0] byte_q_t[$];

  // How the checksum field of a generated datagram is filled in
  typedef enum int {CK_GOOD, CK_NONE, CK_BAD} ck_mode_t;

  // Per-datagram receive state, mirrors what the block keeps
  typedef struct packed {
    logic [16:0] pos;
    logic [31:0] wsum;
    logic [7:0]  hold;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [15:0] ulen;
    logic [15:0] cksum;
    logic [31:0] sip;
    logic [31:0] dip;
  } rx_state_t;

  // One directed byte, with its verdict typed in where it is obvious
  typedef struct {
    udc_pkg::in_item_t  item;
    bit                 typed;
    udc_pkg::out_item_t want;
  } dir_row_t;

  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_BYTES = 340;

  logic               clk;
  logic               rst_n;
  logic               in_push;
  udc_pkg::in_item_t  in_item;
  logic               in_full;
  logic               out_empty;
  logic               out_pop;
  udc_pkg::out_item_t out_item;

  // Sideband that travels with the driven byte
  bit                 drv_typed;
  udc_pkg::out_item_t drv_typed_res;

  rx_state_t          model_st;
  udc_pkg::out_item_t verdict_q[$];

  int send_idle;
  int recv_idle;
  bit hold_start;
  int errors;
  int items_sent;
  int dgrams_sent;
  int checked;
  int verdict_cnt[8];

  udp_datagram_receive_check_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_item  (in_item),
    .in_full  (in_full),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_item (out_item)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Byte-level predictor: advances the state, yields a verdict on the last byte
  function automatic void rx_step(inout rx_state_t st, input udc_pkg::in_item_t it,
                                  output bit has_res, output udc_pkg::out_item_t res);
    logic [16:0] p;
    logic [17:0] size;
    logic [7:0]  b;
    logic [7:0]  v;
    logic [31:0] s;
    logic [15:0] plen;
    logic [15:0] comp;
    p = st.pos;
    b = it.packet_byte;
    res = '0;
    has_res = 1'b0;
    if (p == 17'd0) begin
      st.sip = it.src_ip;
      st.dip = it.dst_ip;
    end
    case (p)
      17'd0: st.sport = {b, 8'h00};
      17'd1: st.sport[7:0] = b;
      17'd2: st.dport = {b, 8'h00};
      17'd3: st.dport[7:0] = b;
      17'd4: st.ulen = {b, 8'h00};
      17'd5: st.ulen[7:0] = b;
      17'd6: st.cksum = {b, 8'h00};
      17'd7: st.cksum[7:0] = b;
      default: ;
    endcase
    // Words inside the UDP length are summed, checksum field as zero
    if (p < 17'd6 || p < {1'b0, st.ulen}) begin
      v = (p == 17'd6 || p == 17'd7) ? 8'h00 : b;
      if (!p[0]) st.hold = v;
      else st.wsum = st.wsum + {16'h0000, st.hold, v};
    end
    if (st.pos != udc_pkg::POS_MAX) st.pos = st.pos + 17'd1;
    if (!it.is_last) return;

    has_res = 1'b1;
    size = {1'b0, p} + 18'd1;
    if (size < {2'b00, udc_pkg::HDR_SIZE}) begin
      res.verdict = udc_pkg::VERDICT_TOO_SHORT;
    end else begin
      res.src_port = st.sport;
      res.dest_port = st.dport;
      res.checksum_present = (st.cksum != 16'h0000);
      if (st.ulen < udc_pkg::HDR_SIZE || {2'b00, st.ulen} > size) begin
        res.verdict = udc_pkg::VERDICT_BAD_LENGTH;
      end else begin
        plen = st.ulen - udc_pkg::HDR_SIZE;
        res.payload_length = plen;
        if (plen > udc_pkg::PAYLOAD_MAX) begin
          res.verdict = udc_pkg::VERDICT_TOO_LARGE;
        end else begin
          // Pseudo header, odd tail padding, fold and invert
          s = st.wsum + {16'h0, st.sip[31:16]} + {16'h0, st.sip[15:0]}
            + {16'h0, st.dip[31:16]} + {16'h0, st.dip[15:0]}
            + {16'h0, udc_pkg::PROTO_UDP} + {16'h0, st.ulen};
          if (st.ulen[0]) s = s + {16'h0, st.hold, 8'h00};
          while (s[31:16] != 16'h0000) s = {16'h0, s[15:0]} + {16'h0, s[31:16]};
          comp = ~s[15:0];
          if (comp == 16'h0000) comp = 16'hffff;
          res.computed_checksum = comp;
          res.verdict = (res.checksum_present && comp != st.cksum) ?
                        udc_pkg::VERDICT_BAD_CHECKSUM : udc_pkg::VERDICT_ACCEPT;
        end
      end
    end
    st = '0;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("MISMATCH %s: got %0h, want %0h", what, got, want);
    errors++;
  endtask

  task automatic check_result(input udc_pkg::out_item_t got,
                              input udc_pkg::out_item_t want);
    if (got.verdict !== want.verdict)
      flag_mismatch("verdict", 32'(got.verdict), 32'(want.verdict));
    if (got.src_port !== want.src_port)
      flag_mismatch("src_port", 32'(got.src_port), 32'(want.src_port));
    if (got.dest_port !== want.dest_port)
      flag_mismatch("dest_port", 32'(got.dest_port), 32'(want.dest_port));
    if (got.payload_length !== want.payload_length)
      flag_mismatch("payload_length", 32'(got.payload_length),
                    32'(want.payload_length));
    if (got.checksum_present !== want.checksum_present)
      flag_mismatch("checksum_present", 32'(got.checksum_present),
                    32'(want.checksum_present));
    if (got.computed_checksum !== want.computed_checksum)
      flag_mismatch("computed_checksum", 32'(got.computed_checksum),
                    32'(want.computed_checksum));
    checked++;
    verdict_cnt[want.verdict]++;
  endtask

  // Monitor: predict on accepted bytes, check on accepted results
  always @(posedge clk) begin : monitor
    bit                 got_res;
    udc_pkg::out_item_t pred;
    if (rst_n) begin
      if (in_push && !in_full) begin
        rx_step(model_st, in_item, got_res, pred);
        if (got_res) verdict_q.push_back(drv_typed ? drv_typed_res : pred);
      end
      if (out_pop && !out_empty) begin
        if (verdict_q.size() == 0)
          flag_mismatch("unexpected result", 32'(out_item.verdict), 32'd0);
        else check_result(out_item, verdict_q.pop_front());
      end
    end
  end

  // Result side: random pops, plus one long hold-off on request
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_start) begin
        hold_start = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_pop <= 1'b0;
        hold_left--;
      end else begin
        out_pop <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // Offer one byte from a falling edge; return at the falling edge after acceptance
  task automatic push_item(input udc_pkg::in_item_t it, input bit typed,
                           input udc_pkg::out_item_t tres);
    while ($urandom_range(99) < send_idle) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push <= 1'b1;
    in_item <= it;
    drv_typed <= typed;
    drv_typed_res <= tres;
    @(posedge clk);
    while (in_full) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // Send a datagram; addresses only matter on the first byte, others get noise
  task automatic send_datagram(input byte_q_t bytes, input logic [31:0] sip,
                               input logic [31:0] dip);
    udc_pkg::in_item_t it;
    for (int i = 0; i < bytes.size(); i++) begin
      it.packet_byte = bytes[i];
      it.src_ip = (i == 0) ? sip : $urandom;
      it.dst_ip = (i == 0) ? dip : $urandom;
      it.is_last = (i == bytes.size() - 1);
      push_item(it, 1'b0, '0);
    end
    dgrams_sent++;
  endtask

  // Build a well-formed datagram; the checksum comes from a scratch predictor run
  function automatic byte_q_t make_udp(input int n_pay, input int n_trail,
                                       input ck_mode_t mode, input logic [31:0] sip,
                                       input logic [31:0] dip);
    byte_q_t            q;
    logic [15:0]        sport;
    logic [15:0]        dport;
    logic [15:0]        ulen;
    logic [15:0]        ck;
    rx_state_t          scr;
    udc_pkg::in_item_t  it;
    bit                 got_res;
    udc_pkg::out_item_t r;
    sport = 16'($urandom);
    dport = 16'($urandom);
    ulen = 16'(8 + n_pay);
    q = {sport[15:8], sport[7:0], dport[15:8], dport[7:0], ulen[15:8], ulen[7:0],
         8'h00, 8'h00};
    for (int i = 0; i < n_pay + n_trail; i++) q.push_back(8'($urandom));
    scr = '0;
    r = '0;
    for (int i = 0; i < q.size(); i++) begin
      it.packet_byte = q[i];
      it.src_ip = sip;
      it.dst_ip = dip;
      it.is_last = (i == q.size() - 1);
      rx_step(scr, it, got_res, r);
    end
    ck = r.computed_checksum;
    case (mode)
      CK_NONE: ck = 16'h0000;
      CK_BAD:  ck = ck ^ 16'($urandom_range(1, 65535));
      default: ;
    endcase
    q[6] = ck[15:8];
    q[7] = ck[7:0];
    return q;
  endfunction

  // One random datagram: mostly well-formed, the rest short, mis-sized or noise
  task automatic send_random_datagram();
    byte_q_t     q;
    int          k;
    int          n_pay;
    int          n_trail;
    int          r;
    int          n;
    ck_mode_t    mode;
    logic [31:0] sip;
    logic [31:0] dip;
    logic [15:0] ulen;
    k = $urandom_range(99);
    sip = $urandom;
    dip = $urandom;
    n_pay = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(12);
    n_trail = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
    r = $urandom_range(99);
    if (r < 80) mode = CK_GOOD;
    else if (r < 90) mode = CK_NONE;
    else mode = CK_BAD;
    if (k < 60) begin
      q = make_udp(n_pay, n_trail, mode, sip, dip);
    end else if (k < 72) begin
      n = $urandom_range(1, 7);
      q = {};
      for (int i = 0; i < n; i++) q.push_back(8'($urandom));
    end else if (k < 87) begin
      // Length field below the header size or past the received bytes
      q = make_udp(n_pay, n_trail, mode, sip, dip);
      ulen = ($urandom_range(1) == 0) ? 16'($urandom_range(7)) :
             16'(q.size() + $urandom_range(1, 60));
      q[4] = ulen[15:8];
      q[5] = ulen[7:0];
    end else begin
      n = $urandom_range(8, 24);
      q = {};
      for (int i = 0; i < n; i++) q.push_back(8'($urandom));
    end
    send_datagram(q, sip, dip);
  endtask

  function automatic dir_row_t row(input logic [7:0] b, input logic [31:0] sip,
                                   input logic [31:0] dip, input logic last,
                                   input bit typed, input udc_pkg::out_item_t want);
    dir_row_t d;
    d.item.packet_byte = b;
    d.item.src_ip = sip;
    d.item.dst_ip = dip;
    d.item.is_last = last;
    d.typed = typed;
    d.want = want;
    return d;
  endfunction

  initial begin : main
    dir_row_t           dir_tab[$];
    udc_pkg::out_item_t w_short;
    udc_pkg::out_item_t w_badlen;
    int                 start;
    int                 dstart;
    int                 drain;

    rst_n = 1'b0;
    in_push = 1'b0;
    in_item = '0;
    drv_typed = 1'b0;
    drv_typed_res = '0;
    send_idle = 0;
    recv_idle = 0;
    hold_start = 1'b0;
    errors = 0;
    items_sent = 0;
    dgrams_sent = 0;
    checked = 0;
    model_st = '0;

    // Known verdicts
    w_short = '0;
    w_short.verdict = udc_pkg::VERDICT_TOO_SHORT;
    w_badlen = '0;
    w_badlen.verdict = udc_pkg::VERDICT_BAD_LENGTH;
    w_badlen.src_port = 16'hffff;
    w_badlen.dest_port = 16'hffff;
    w_badlen.checksum_present = 1'b1;

    // Single byte datagram: too short
    dir_tab.push_back(row(8'hff, '1, '1, 1'b1, 1'b1, w_short));
    // All-ones header, length 0xffff past the 8 bytes: bad length
    for (int i = 0; i < 8; i++)
      dir_tab.push_back(row(8'hff, (i == 0) ? '1 : '0, (i == 0) ? '1 : '0,
                            i == 7, i == 7, (i == 7) ? w_badlen : '0));
    // Minimal header, length 8, no checksum, zero addresses
    dir_tab.push_back(row(8'h00, '0, '0, 1'b0, 1'b0, '0));
    dir_tab.push_back(row(8'h00, '1, '1, 1'b0, 1'b0, '0));
    dir_tab.push_back(row(8'h00, '0, '0, 1'b0, 1'b0, '0));
    dir_tab.push_back(row(8'h00, '0, '0, 1'b0, 1'b0, '0));
    dir_tab.push_back(row(8'h00, '0, '0, 1'b0, 1'b0, '0));
    dir_tab.push_back(row(8'h08, '0, '0, 1'b0, 1'b0, '0));
    dir_tab.push_back(row(8'h00, '0, '0, 1'b0, 1'b0, '0));
    dir_tab.push_back(row(8'h00, '0, '0, 1'b1, 1'b0, '0));
    // Odd length 9 with a nonzero checksum, padded last byte
    dir_tab.push_back(row(8'h80, 32'h8000_0001, 32'h7fff_fffe, 1'b0, 1'b0, '0));
    dir_tab.push_back(row(8'h00, '0, '0, 1'b0, 1'b0, '0));
    dir_tab.push_back(row(8'h00, '0, '0, 1'b0, 1'b0, '0));
    dir_tab.push_back(row(8'h01, '0, '0, 1'b0, 1'b0, '0));
    dir_tab.push_back(row(8'h00, '0, '0, 1'b0, 1'b0, '0));
    dir_tab.push_back(row(8'h09, '0, '0, 1'b0, 1'b0, '0));
    dir_tab.push_back(row(8'h00, '0, '0, 1'b0, 1'b0, '0));
    dir_tab.push_back(row(8'h01, '0, '0, 1'b0, 1'b0, '0));
    dir_tab.push_back(row(8'ha5, '0, '0, 1'b1, 1'b0, '0));

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part
    foreach (dir_tab[i]) push_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].want);
    dgrams_sent += 4;

    // Random part in three idling phases
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 7 : (ph == 1) ? 74 : 0;
      recv_idle = (ph == 0) ? 74 : (ph == 1) ? 7 : 0;
      if (ph == 0) hold_start = 1'b1;
      start = items_sent;
      dstart = dgrams_sent;
      while (items_sent - start < PHASE_BYTES || dgrams_sent - dstart < 15)
        send_random_datagram();
    end

    in_push <= 1'b0;

    // Drain outstanding verdicts, then let the pipe settle
    drain = 0;
    while (verdict_q.size() != 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    if (verdict_q.size() != 0) begin
      $display("%0d expected verdicts never arrived", verdict_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
    repeat (20) @(posedge clk);

    $display("Sent %0d bytes in %0d datagrams, checked %0d verdicts", items_sent,
             dgrams_sent, checked);
    $display("accept %0d, too short %0d, bad length %0d, too large %0d, bad checksum %0d",
             verdict_cnt[udc_pkg::VERDICT_ACCEPT], verdict_cnt[udc_pkg::VERDICT_TOO_SHORT],
             verdict_cnt[udc_pkg::VERDICT_BAD_LENGTH],
             verdict_cnt[udc_pkg::VERDICT_TOO_LARGE],
             verdict_cnt[udc_pkg::VERDICT_BAD_CHECKSUM]);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/udc_pkg.sv
hdl/udc_fifo.sv
hdl/udc_front.sv
hdl/udc_back.sv
hdl/udp_datagram_receive_check_core.sv
tb/tb_udp_datagram_receive_check_core.sv
